// ===== rtl/ftrl_pkg.sv =====
package ftrl_pkg;

    typedef struct packed {
        logic [15:0] feature_index;
        logic        last_feature;
        logic        target;
        logic        train;
    } t_in_word;

    typedef struct packed {
        logic [15:0]        probability;
        logic signed [31:0] raw_score;
        logic               row_overflow;
    } t_out_word;

    typedef struct packed {
        logic signed [31:0] z;
        logic [31:0]        n;
        logic signed [31:0] w;
    } t_entry;

    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 32;
    localparam int REG_W      = 31;

    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA      = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BETA       = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LAMBDA_ONE = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LAMBDA_TWO = 8'd3;

    localparam logic [REG_W-1:0] ALPHA_RESET      = 31'd328;
    localparam logic [REG_W-1:0] BETA_RESET       = 31'd65536;
    localparam logic [REG_W-1:0] LAMBDA_ONE_RESET = 31'd0;
    localparam logic [REG_W-1:0] LAMBDA_TWO_RESET = 31'd65536;

    localparam int SQ_RAD_W  = 48;
    localparam int SQ_ROOT_W = 24;
    localparam int SQ_REM_W  = 26;
    localparam int DIV_W     = 49;
    localparam int SUM_W     = 40;

    localparam logic [31:0] SIG_SAT_LIMIT = 32'h0008_0000;

    function automatic logic [15:0] sig_entry(input logic [4:0] k);
        logic [15:0] v;
        case (k)
            5'd0:    v = 16'd32768;
            5'd1:    v = 16'd40793;
            5'd2:    v = 16'd47911;
            5'd3:    v = 16'd53581;
            5'd4:    v = 16'd57724;
            5'd5:    v = 16'd60565;
            5'd6:    v = 16'd62428;
            5'd7:    v = 16'd63615;
            5'd8:    v = 16'd64357;
            5'd9:    v = 16'd64816;
            5'd10:   v = 16'd65097;
            5'd11:   v = 16'd65269;
            5'd12:   v = 16'd65374;
            5'd13:   v = 16'd65438;
            5'd14:   v = 16'd65476;
            5'd15:   v = 16'd65500;
            default: v = 16'd65514;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/ftrl_logistic_predict_update_unit.sv =====
// FTRL-proximal logistic regression, predict and update.
// A row enters on the input channel as a series of words, one hashed feature slot
// each, with last_feature set on the final word; target and train are taken from
// that final word. Each word is answered by nothing, except the final word, which
// yields one output word holding the probability, the saturated row score and the
// overflow flag. Words past MAX_ROW_FEATURES only raise the overflow flag.
// The block works on one word at a time. A feature word passes a slot reduction
// (S_MOD1 to S_MOD3), a memory read, a 24-step square root and two 49-step
// divisions on the shared restoring divider; the root and divisions are skipped when
// its weight is zero. A final word then loads the output register in S_SIG1, S_SIG2
// and S_OUT, and S_DONE closes the row. With train set, g*g is formed once; then each
// feature of the row gets two square roots, one division and an entry read-modify-write.
// The output register holds a result until it is taken; while it is full a new
// final word waits before its result is written, and no further input word is accepted.
// After reset, and after every write to one of the four registers, z and n in the
// memory are cleared one entry per cycle through all TABLE_DEPTH entries, during which
// no input word is accepted. Stored weights are kept. Configuration writes are always
// accepted.
module ftrl_logistic_predict_update_unit #(
    parameter int TABLE_DEPTH      = 65536,
    parameter int MAX_ROW_FEATURES = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  ftrl_pkg::t_in_word                  i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output ftrl_pkg::t_out_word                 o_out_data,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [ftrl_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [ftrl_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import ftrl_pkg::*;

    localparam int AW  = $clog2(TABLE_DEPTH);
    localparam int RIW = (MAX_ROW_FEATURES > 1) ? $clog2(MAX_ROW_FEATURES) : 1;
    localparam int CW  = $clog2(MAX_ROW_FEATURES + 1);
    localparam logic [63:0] RECIP_FULL = (64'd1 << 32) / TABLE_DEPTH;
    localparam logic [28:0] RECIP      = RECIP_FULL[28:0];
    localparam logic [24:0] TD_C       = 25'(TABLE_DEPTH);
    localparam logic [AW-1:0] CLR_LAST = AW'(TABLE_DEPTH - 1);
    localparam logic [CW-1:0] ROW_MAX  = CW'(MAX_ROW_FEATURES);

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_MOD1  = 5'd1;
    localparam logic [4:0] S_MOD2  = 5'd2;
    localparam logic [4:0] S_MOD3  = 5'd3;
    localparam logic [4:0] S_RD    = 5'd4;
    localparam logic [4:0] S_DER   = 5'd5;
    localparam logic [4:0] S_DSQ   = 5'd6;
    localparam logic [4:0] S_DQ1   = 5'd7;
    localparam logic [4:0] S_DDIV1 = 5'd8;
    localparam logic [4:0] S_DDEN  = 5'd9;
    localparam logic [4:0] S_DDIV2 = 5'd10;
    localparam logic [4:0] S_DW    = 5'd11;
    localparam logic [4:0] S_DWR   = 5'd12;
    localparam logic [4:0] S_SIG1  = 5'd13;
    localparam logic [4:0] S_SIG2  = 5'd14;
    localparam logic [4:0] S_OUT   = 5'd15;
    localparam logic [4:0] S_G2    = 5'd16;
    localparam logic [4:0] S_TIDX  = 5'd17;
    localparam logic [4:0] S_TSLOT = 5'd18;
    localparam logic [4:0] S_TRD   = 5'd19;
    localparam logic [4:0] S_TLD   = 5'd20;
    localparam logic [4:0] S_TSQ1  = 5'd21;
    localparam logic [4:0] S_TSQS  = 5'd22;
    localparam logic [4:0] S_TSQ2  = 5'd23;
    localparam logic [4:0] S_TDQ   = 5'd24;
    localparam logic [4:0] S_TDIV  = 5'd25;
    localparam logic [4:0] S_TMUL  = 5'd26;
    localparam logic [4:0] S_TWR   = 5'd27;
    localparam logic [4:0] S_DONE  = 5'd28;

    logic [4:0] r_state, n_state;

    logic [REG_W-1:0] r_alpha, r_beta, r_lambda_one, r_lambda_two;
    logic             r_clr;
    logic [AW-1:0]    r_clr_addr;

    t_in_word             r_item;
    logic [44:0]          r_mprod;
    logic [37:0]          r_mq;
    logic [AW-1:0]        r_slot;
    t_entry               r_rd;
    logic signed [31:0]   r_z, r_w;
    logic [31:0]          r_n, r_mag, r_nn;
    logic                 r_zpos;
    logic signed [SUM_W-1:0] r_sum;
    logic [CW-1:0]        r_count, r_k;
    logic                 r_drop;

    logic [SQ_RAD_W-1:0]  r_sq_rad;
    logic [SQ_REM_W-1:0]  r_sq_rem;
    logic [SQ_ROOT_W-1:0] r_sq_root, r_root_a;
    logic [4:0]           r_sq_cnt;

    logic [DIV_W-1:0]     r_dv_num, r_dv_rem, r_dv_den;
    logic [5:0]           r_dv_cnt;

    logic signed [31:0]   r_raw;
    logic [15:0]          r_sbase, r_sdiff, r_prob;
    logic [14:0]          r_sf;
    logic signed [17:0]   r_g;
    logic [16:0]          r_g2;
    logic [47:0]          r_t;

    logic [AW-1:0]        r_row_rd;
    logic                 r_out_valid;
    t_out_word            r_out;

    t_entry               mem [TABLE_DEPTH];
    logic [AW-1:0]        row_mem [MAX_ROW_FEATURES];

    logic                 mem_we;
    logic [AW-1:0]        mem_wa;
    t_entry               mem_wd;

    logic [REG_W-1:0]     alpha_eff;
    logic                 sq_done, dv_done, cfg_hit, in_acc;
    logic [SQ_REM_W-1:0]  sq_rem2, sq_trial;
    logic [DIV_W:0]       dv_rem2;
    logic [37:0]          mod_r, mod_s;
    logic [31:0]          az, sat_az, wmag, sig_sat, nn_sat;
    logic [32:0]          nn_sum;
    logic [49:0]          den_sum;
    logic signed [40:0]   sum41;
    logic signed [SUM_W-1:0] sum_sat;
    logic signed [31:0]   raw_sat, w_new, zn_sat;
    logic [30:0]          wm;
    logic [16:0]          sig_v, prob_v;
    logic signed [49:0]   zn;
    logic [31:0]          sig_abs;
    logic [4:0]           sig_idx;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == S_IDLE) && !r_clr;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign in_acc      = i_in_valid && o_in_ready;
    assign cfg_hit     = i_cfg_valid && (i_cfg_index == CFG_ALPHA || i_cfg_index == CFG_BETA ||
                         i_cfg_index == CFG_LAMBDA_ONE || i_cfg_index == CFG_LAMBDA_TWO);
    assign alpha_eff   = (r_alpha == '0) ? 31'd1 : r_alpha;
    assign sq_done     = (r_sq_cnt == 5'(SQ_ROOT_W - 1));
    assign dv_done     = (r_dv_cnt == 6'(DIV_W - 1));

    always_comb begin
        sq_rem2  = {r_sq_rem[SQ_REM_W-3:0], r_sq_rad[SQ_RAD_W-1:SQ_RAD_W-2]};
        sq_trial = {r_sq_root, 2'b01};
        dv_rem2  = {r_dv_rem, r_dv_num[DIV_W-1]};

        mod_r = 38'(r_item.feature_index) - r_mq;
        mod_s = (mod_r >= 38'(TD_C)) ? mod_r - 38'(TD_C) : mod_r;

        az     = r_rd.z[31] ? 32'(-33'(r_rd.z)) : 32'(r_rd.z);
        sat_az = az - {1'b0, r_lambda_one};

        den_sum = 50'(r_dv_num) + 50'(r_lambda_two);
        if (den_sum == '0) begin
            den_sum = 50'd1;
        end

        wm    = (r_dv_num > 49'h7FFF_FFFF) ? 31'h7FFF_FFFF : r_dv_num[30:0];
        w_new = r_zpos ? -$signed({1'b0, wm}) : $signed({1'b0, wm});

        sum41 = {r_sum[SUM_W-1], r_sum} + {{9{r_w[31]}}, r_w};
        if (sum41[40] != sum41[39]) begin
            sum_sat = sum41[40] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
        end else begin
            sum_sat = sum41[SUM_W-1:0];
        end

        if (r_sum[SUM_W-1:31] == '0 || r_sum[SUM_W-1:31] == '1) begin
            raw_sat = r_sum[31:0];
        end else begin
            raw_sat = r_sum[SUM_W-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end

        sig_abs = raw_sat[31] ? 32'(-33'(raw_sat)) : 32'(raw_sat);
        sig_idx = 5'(sig_abs >> 15);
        sig_v   = 17'(r_sbase) + 17'((32'(r_sdiff) * 32'(r_sf)) >> 15);
        prob_v  = r_raw[31] ? 17'd65536 - sig_v : sig_v;

        nn_sum = 33'(r_rd.n) + 33'(r_g2);
        nn_sat = nn_sum[32] ? 32'hFFFF_FFFF : nn_sum[31:0];

        sig_sat = (r_dv_num > 49'hFFFF_FFFF) ? 32'hFFFF_FFFF : r_dv_num[31:0];
        wmag    = r_w[31] ? 32'(-33'(r_w)) : 32'(r_w);

        zn = 50'(r_z) + 50'(r_g);
        if (r_w[31]) begin
            zn = zn + $signed({2'b00, r_t});
        end else begin
            zn = zn - $signed({2'b00, r_t});
        end
        if (zn > 50'sh0_7FFF_FFFF) begin
            zn_sat = 32'sh7FFF_FFFF;
        end else if (zn < -50'sh0_8000_0000) begin
            zn_sat = 32'sh8000_0000;
        end else begin
            zn_sat = zn[31:0];
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (r_count < ROW_MAX) begin
                        n_state = S_MOD1;
                    end else if (i_in_data.last_feature) begin
                        n_state = S_SIG1;
                    end
                end
            end
            S_MOD1:  n_state = S_MOD2;
            S_MOD2:  n_state = S_MOD3;
            S_MOD3:  n_state = S_RD;
            S_RD:    n_state = S_DER;
            S_DER:   n_state = (az <= {1'b0, r_lambda_one}) ? S_DWR : S_DSQ;
            S_DSQ:   n_state = sq_done ? S_DQ1 : S_DSQ;
            S_DQ1:   n_state = S_DDIV1;
            S_DDIV1: n_state = dv_done ? S_DDEN : S_DDIV1;
            S_DDEN:  n_state = S_DDIV2;
            S_DDIV2: n_state = dv_done ? S_DW : S_DDIV2;
            S_DW:    n_state = S_DWR;
            S_DWR:   n_state = r_item.last_feature ? S_SIG1 : S_IDLE;
            S_SIG1:  n_state = S_SIG2;
            S_SIG2:  n_state = S_OUT;
            S_OUT: begin
                if (!r_out_valid) begin
                    n_state = (r_item.train && r_count != '0) ? S_G2 : S_DONE;
                end
            end
            S_G2:    n_state = S_TIDX;
            S_TIDX:  n_state = S_TSLOT;
            S_TSLOT: n_state = S_TRD;
            S_TRD:   n_state = S_TLD;
            S_TLD:   n_state = S_TSQ1;
            S_TSQ1:  n_state = sq_done ? S_TSQS : S_TSQ1;
            S_TSQS:  n_state = S_TSQ2;
            S_TSQ2:  n_state = sq_done ? S_TDQ : S_TSQ2;
            S_TDQ:   n_state = S_TDIV;
            S_TDIV:  n_state = dv_done ? S_TMUL : S_TDIV;
            S_TMUL:  n_state = S_TWR;
            S_TWR:   n_state = (CW'(r_k + 1'b1) == r_count) ? S_DONE : S_TIDX;
            S_DONE:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        mem_we = r_clr || (r_state == S_DWR) || (r_state == S_TWR);
        mem_wa = r_clr ? r_clr_addr : r_slot;
        if (r_clr) begin
            mem_wd = '0;
        end else if (r_state == S_DWR) begin
            mem_wd = '{z: r_z, n: r_n, w: r_w};
        end else begin
            mem_wd = '{z: zn_sat, n: r_nn, w: r_w};
        end
    end

    // The clearing pass resets z and n only; the weight field keeps its value.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa].z <= mem_wd.z;
            mem[mem_wa].n <= mem_wd.n;
            if (!r_clr) begin
                mem[mem_wa].w <= mem_wd.w;
            end
        end
        r_rd <= mem[r_slot];
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DWR) begin
            row_mem[r_count[RIW-1:0]] <= r_slot;
        end
        r_row_rd <= row_mem[r_k[RIW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_alpha      <= ALPHA_RESET;
            r_beta       <= BETA_RESET;
            r_lambda_one <= LAMBDA_ONE_RESET;
            r_lambda_two <= LAMBDA_TWO_RESET;
            r_clr        <= 1'b1;
            r_clr_addr   <= '0;
            r_sum        <= '0;
            r_count      <= '0;
            r_drop       <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (cfg_hit) begin
                r_clr      <= 1'b1;
                r_clr_addr <= '0;
            end else if (r_clr) begin
                if (r_clr_addr == CLR_LAST) begin
                    r_clr <= 1'b0;
                end else begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                end
            end
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_ALPHA:      r_alpha      <= i_cfg_data[REG_W-1:0];
                    CFG_BETA:       r_beta       <= i_cfg_data[REG_W-1:0];
                    CFG_LAMBDA_ONE: r_lambda_one <= i_cfg_data[REG_W-1:0];
                    CFG_LAMBDA_TWO: r_lambda_two <= i_cfg_data[REG_W-1:0];
                    default: ;
                endcase
            end
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc && r_count >= ROW_MAX) begin
                        r_drop <= 1'b1;
                    end
                end
                S_DWR: begin
                    r_sum   <= sum_sat;
                    r_count <= r_count + 1'b1;
                end
                S_OUT: begin
                    if (!r_out_valid) begin
                        r_out_valid <= 1'b1;
                    end
                end
                S_DONE: begin
                    r_sum   <= '0;
                    r_count <= '0;
                    r_drop  <= 1'b0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    r_item <= i_in_data;
                end
            end
            S_MOD1: r_mprod <= 45'(r_item.feature_index) * 45'(RECIP);
            S_MOD2: r_mq    <= 38'(r_mprod[44:32]) * 38'(TD_C);
            S_MOD3: r_slot  <= mod_s[AW-1:0];
            S_DER: begin
                r_z      <= r_rd.z;
                r_n      <= r_rd.n;
                r_w      <= '0;
                r_mag    <= sat_az;
                r_zpos   <= !r_rd.z[31];
                r_sq_rad <= {r_rd.n, 16'd0};
                r_sq_rem <= '0;
                r_sq_root <= '0;
                r_sq_cnt <= '0;
            end
            S_DSQ, S_TSQ1, S_TSQ2: begin
                r_sq_rad <= {r_sq_rad[SQ_RAD_W-3:0], 2'b00};
                r_sq_cnt <= r_sq_cnt + 1'b1;
                if (sq_rem2 >= sq_trial) begin
                    r_sq_rem  <= sq_rem2 - sq_trial;
                    r_sq_root <= {r_sq_root[SQ_ROOT_W-2:0], 1'b1};
                end else begin
                    r_sq_rem  <= sq_rem2;
                    r_sq_root <= {r_sq_root[SQ_ROOT_W-2:0], 1'b0};
                end
            end
            S_DQ1: begin
                r_dv_num <= DIV_W'({32'(r_beta) + 32'(r_sq_root), 16'd0});
                r_dv_den <= DIV_W'(alpha_eff);
                r_dv_rem <= '0;
                r_dv_cnt <= '0;
            end
            S_DDIV1, S_DDIV2, S_TDIV: begin
                r_dv_cnt <= r_dv_cnt + 1'b1;
                if (dv_rem2 >= {1'b0, r_dv_den}) begin
                    r_dv_rem <= DIV_W'(dv_rem2 - {1'b0, r_dv_den});
                    r_dv_num <= {r_dv_num[DIV_W-2:0], 1'b1};
                end else begin
                    r_dv_rem <= dv_rem2[DIV_W-1:0];
                    r_dv_num <= {r_dv_num[DIV_W-2:0], 1'b0};
                end
            end
            S_DDEN: begin
                r_dv_num <= DIV_W'({r_mag, 16'd0});
                r_dv_den <= den_sum[DIV_W-1:0];
                r_dv_rem <= '0;
                r_dv_cnt <= '0;
            end
            S_DW: r_w <= w_new;
            S_SIG1: begin
                r_raw <= raw_sat;
                if (sig_abs >= SIG_SAT_LIMIT) begin
                    r_sbase <= sig_entry(5'd16);
                    r_sdiff <= '0;
                    r_sf    <= '0;
                end else begin
                    r_sbase <= sig_entry(sig_idx);
                    r_sdiff <= sig_entry(5'(sig_idx + 5'd1)) - sig_entry(sig_idx);
                    r_sf    <= sig_abs[14:0];
                end
                r_k <= '0;
            end
            S_SIG2: begin
                r_prob <= prob_v[15:0];
            end
            S_OUT: begin
                if (!r_out_valid) begin
                    r_out.probability  <= r_prob;
                    r_out.raw_score    <= r_raw;
                    r_out.row_overflow <= r_drop;
                    r_g <= $signed({2'b00, r_prob}) - (r_item.target ? 18'sd65536 : 18'sd0);
                end
            end
            S_G2: begin
                r_g2 <= 17'((36'(r_g) * 36'(r_g)) >> 16);
            end
            S_TSLOT: r_slot <= r_row_rd;
            S_TLD: begin
                r_z      <= r_rd.z;
                r_n      <= r_rd.n;
                r_w      <= r_rd.w;
                r_nn     <= nn_sat;
                r_sq_rad <= {nn_sat, 16'd0};
                r_sq_rem <= '0;
                r_sq_root <= '0;
                r_sq_cnt <= '0;
            end
            S_TSQS: begin
                r_root_a <= r_sq_root;
                r_sq_rad <= {r_n, 16'd0};
                r_sq_rem <= '0;
                r_sq_root <= '0;
                r_sq_cnt <= '0;
            end
            S_TDQ: begin
                r_dv_num <= DIV_W'({r_root_a - r_sq_root, 16'd0});
                r_dv_den <= DIV_W'(alpha_eff);
                r_dv_rem <= '0;
                r_dv_cnt <= '0;
            end
            S_TMUL: r_t <= 48'((64'(sig_sat) * 64'(wmag)) >> 16);
            S_TWR:  r_k <= r_k + 1'b1;
            default: ;
        endcase
    end

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import ftrl_pkg::*;

    localparam int SLOTS   = 65536;
    localparam int ROW_MAX = 64;

    class row_score_predictor;
        logic [30:0]     alpha, beta, lambda_one, lambda_two;
        int              z_tab[SLOTS];
        int unsigned     n_tab[SLOTS];
        int              w_tab[SLOTS];
        int unsigned     row_slots[ROW_MAX];
        longint          row_sum;
        int              row_cnt;
        bit              dropped;
        t_out_word       expected_scores[$];
        int              errors;
        int unsigned     sig_tab[17] = '{32768, 40793, 47911, 53581, 57724, 60565, 62428,
            63615, 64357, 64816, 65097, 65269, 65374, 65438, 65476, 65500, 65514};

        function new();
            alpha = ALPHA_RESET;
            beta = BETA_RESET;
            lambda_one = LAMBDA_ONE_RESET;
            lambda_two = LAMBDA_TWO_RESET;
            clear_tables();
            row_sum = 0;
            row_cnt = 0;
            dropped = 0;
            errors = 0;
        endfunction

        function void clear_tables();
            foreach (z_tab[i]) begin
                z_tab[i] = 0;
                n_tab[i] = 0;
            end
        endfunction

        function longint unsigned isqrt(longint unsigned v);
            longint unsigned r, b;
            r = 0;
            b = 64'd1 << 62;
            while (b > v) b = b >> 2;
            while (b != 0) begin
                if (v >= r + b) begin
                    v = v - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
            return r;
        endfunction

        function longint unsigned sqrt_q16(longint unsigned x);
            return isqrt(x << 16);
        endfunction

        function longint unsigned alpha_eff();
            return (alpha == 0) ? 64'd1 : 64'(alpha);
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
            case (idx)
                CFG_ALPHA:      alpha = d[30:0];
                CFG_BETA:       beta = d[30:0];
                CFG_LAMBDA_ONE: lambda_one = d[30:0];
                CFG_LAMBDA_TWO: lambda_two = d[30:0];
                default:        return;
            endcase
            clear_tables();
        endfunction

        function int weight_of(int unsigned slot);
            int              z;
            longint unsigned az, mag, q, den, wm;
            z = z_tab[slot];
            az = (z < 0) ? longint'(-longint'(z)) : longint'(z);
            if (az <= 64'(lambda_one)) return 0;
            mag = az - 64'(lambda_one);
            q = ((64'(beta) + sqrt_q16(64'(n_tab[slot]))) << 16) / alpha_eff();
            den = q + 64'(lambda_two);
            if (den == 0) den = 1;
            wm = (mag << 16) / den;
            if (wm > 64'h7FFF_FFFF) wm = 64'h7FFF_FFFF;
            return (z > 0) ? -int'(wm) : int'(wm);
        endfunction

        function int unsigned sigmoid(int s);
            longint unsigned a;
            int unsigned     v, k, f;
            a = (s < 0) ? longint'(-longint'(s)) : longint'(s);
            if (a >= (64'd8 << 16)) begin
                v = sig_tab[16];
            end else begin
                k = 32'(a >> 15);
                f = 32'(a & 64'h7FFF);
                v = sig_tab[k] + (((sig_tab[k+1] - sig_tab[k]) * f) >> 15);
            end
            return (s < 0) ? 65536 - v : v;
        endfunction

        function void update_row(int unsigned prob, bit tgt);
            longint          g, tw, zn;
            longint unsigned g2, n, nn, sg, wmag, t;
            int unsigned     slot;
            int              w;
            g = longint'(prob) - (tgt ? 65536 : 0);
            g2 = longint'(g * g) >> 16;
            for (int k = 0; k < row_cnt; k++) begin
                slot = row_slots[k];
                n = n_tab[slot];
                nn = n + g2;
                if (nn > 64'hFFFF_FFFF) nn = 64'hFFFF_FFFF;
                w = w_tab[slot];
                sg = ((sqrt_q16(nn) - sqrt_q16(n)) << 16) / alpha_eff();
                if (sg > 64'hFFFF_FFFF) sg = 64'hFFFF_FFFF;
                wmag = (w < 0) ? longint'(-longint'(w)) : longint'(w);
                t = (sg * wmag) >> 16;
                tw = (w < 0) ? -longint'(t) : longint'(t);
                zn = longint'(z_tab[slot]) + g - tw;
                if (zn > 64'sd2147483647) zn = 64'sd2147483647;
                if (zn < -64'sd2147483648) zn = -64'sd2147483648;
                z_tab[slot] = int'(zn);
                n_tab[slot] = nn[31:0];
            end
        endfunction

        function void take_feature(t_in_word wd);
            int unsigned slot;
            int          w;
            longint      raw;
            t_out_word   res;
            slot = wd.feature_index;
            if (row_cnt < ROW_MAX) begin
                w = weight_of(slot);
                w_tab[slot] = w;
                row_sum = row_sum + w;
                if (row_sum > 64'sd549755813887) row_sum = 64'sd549755813887;
                if (row_sum < -64'sd549755813888) row_sum = -64'sd549755813888;
                row_slots[row_cnt] = slot;
                row_cnt++;
            end else begin
                dropped = 1;
            end
            if (!wd.last_feature) return;
            raw = row_sum;
            if (raw > 64'sd2147483647) raw = 64'sd2147483647;
            if (raw < -64'sd2147483648) raw = -64'sd2147483648;
            res.raw_score = raw[31:0];
            res.probability = 16'(sigmoid(int'(raw)));
            res.row_overflow = dropped;
            expected_scores = {expected_scores, res};
            if (wd.train) update_row(sigmoid(int'(raw)), wd.target);
            row_sum = 0;
            row_cnt = 0;
            dropped = 0;
        endfunction

        function void check_score(t_out_word got);
            t_out_word exp_w;
            if (expected_scores.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected output word %h", got);
                return;
            end
            exp_w = expected_scores.pop_front();
            if (got !== exp_w) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: exp prob %0d score %0d ovf %0d, got %0d %0d %0d",
                             exp_w.probability, exp_w.raw_score, exp_w.row_overflow,
                             got.probability, got.raw_score, got.row_overflow);
            end
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_ready;
    t_in_word              i_in_data;
    logic                  o_out_valid;
    logic                  i_out_ready;
    t_out_word             o_out_data;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    row_score_predictor model = new();
    int                 scores_seen = 0;

    ftrl_logistic_predict_update_unit dut (.*);

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 65) return 0;
        if (r < 95) return $urandom_range(1, 4);
        return $urandom_range(10, 80);
    endfunction

    task automatic send_word(t_in_word wd);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= wd;
        do @(posedge i_clk); while (!o_in_ready);
        model.take_feature(wd);
    endtask

    task automatic send_row(int len, bit pooled, bit trn);
        t_in_word wd;
        int       r;
        for (int k = 0; k < len; k++) begin
            r = $urandom_range(99);
            if (pooled && r < 75) wd.feature_index = 16'($urandom_range(15));
            else if (r < 90) wd.feature_index = 16'($urandom);
            else wd.feature_index = $urandom_range(1) ? 16'hFFFF : 16'h0000;
            wd.last_feature = (k == len - 1);
            wd.target = 1'($urandom_range(1));
            wd.train = (k == len - 1) ? trn : 1'($urandom_range(1));
            send_word(wd);
        end
    endtask

    task automatic random_rows(int n_items);
        int sent, len, r;
        sent = 0;
        while (sent < n_items) begin
            r = $urandom_range(99);
            if (r < 85) len = $urandom_range(1, 6);
            else if (r < 96) len = $urandom_range(7, 20);
            else len = $urandom_range(ROW_MAX + 1, ROW_MAX + 6);
            send_row(len, $urandom_range(9) != 0, $urandom_range(3) != 0);
            sent += len;
        end
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        while (model.expected_scores.size() != 0) @(posedge i_clk);
        repeat (8000) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= d;
        do @(posedge i_clk); while (!o_cfg_ready);
        model.set_reg(idx, d);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic directed_rows();
        t_in_word wd;
        wd = '{feature_index: 16'h0000, last_feature: 1'b1, target: 1'b1, train: 1'b1};
        send_word(wd);
        wd = '{feature_index: 16'hFFFF, last_feature: 1'b1, target: 1'b0, train: 1'b1};
        send_word(wd);
        repeat (4) begin
            wd = '{feature_index: 16'd1, last_feature: 1'b0, target: 1'b0, train: 1'b0};
            send_word(wd);
            wd = '{feature_index: 16'd2, last_feature: 1'b0, target: 1'b1, train: 1'b1};
            send_word(wd);
            wd = '{feature_index: 16'd1, last_feature: 1'b1, target: 1'b1, train: 1'b1};
            send_word(wd);
        end
        wd = '{feature_index: 16'd1, last_feature: 1'b0, target: 1'b0, train: 1'b1};
        send_word(wd);
        wd = '{feature_index: 16'd2, last_feature: 1'b1, target: 1'b1, train: 1'b0};
        send_word(wd);
        wd = '{feature_index: 16'hAAAA, last_feature: 1'b1, target: 1'b0, train: 1'b0};
        send_word(wd);
        wd = '{feature_index: 16'h5555, last_feature: 1'b1, target: 1'b1, train: 1'b1};
        send_word(wd);
    endtask

    initial begin
        int stall_left;
        bit nxt;
        stall_left = 0;
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready) begin
                model.check_score(o_out_data);
                scores_seen++;
                if (scores_seen == 25) stall_left = 6000;
            end
            if (stall_left > 0) begin
                stall_left--;
                nxt = 1'b0;
            end else if ($urandom_range(99) < 75) begin
                nxt = 1'b1;
            end else begin
                stall_left = pick_gap();
                nxt = 1'b0;
            end
            i_out_ready <= nxt;
        end
    end

    initial begin
        i_rst_n <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_data <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        directed_rows();
        random_rows(150);
        settle();

        write_reg(CFG_ALPHA, 32'h7FFF_FFFF);
        write_reg(CFG_BETA, 32'h0000_0000);
        write_reg(CFG_LAMBDA_TWO, 32'h0000_0000);
        random_rows(150);
        settle();

        write_reg(CFG_ALPHA, 32'h8000_0000);
        write_reg(CFG_BETA, 32'hFFFF_FFFF);
        write_reg(CFG_LAMBDA_ONE, 32'h7FFF_FFFF);
        write_reg(CFG_LAMBDA_TWO, 32'h7FFF_FFFF);
        random_rows(60);
        settle();

        write_reg(8'hFF, $urandom);
        write_reg(CFG_ALPHA, 32'h0001_0000);
        write_reg(CFG_BETA, 32'h0001_0000);
        write_reg(CFG_LAMBDA_ONE, 32'h0000_199A);
        write_reg(CFG_LAMBDA_TWO, 32'h0000_0000);
        random_rows(240);
        settle();

        if (model.errors == 0 && model.expected_scores.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin
        #40_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
